// File: hdl/rswm_pkg.sv
// Package for the row sliding window mean unit.
// Holds widths, limits, register indexes and the divider request type.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rswm_pkg;

   localparam int PIXEL_W      = 8;
   localparam int SUM_W        = 14;
   localparam int COL_W        = 12;
   localparam int WIN_W        = 7;
   localparam int ROW_W        = 13;
   localparam int MAX_WINDOW   = 64;
   localparam int WIN_IDX_W    = 6;
   localparam int MAX_ROW_WIDTH = 4096;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int DIV_STEPS    = 14;
   localparam int STEP_W       = 4;

   localparam logic [WIN_W-1:0] WIN_RESET = 7'd8;
   localparam logic [ROW_W-1:0] ROW_RESET = 13'd640;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH  = 2'd1;

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   dividend;
      logic [WIN_W-1:0]   divisor;
   } div_req_type;

endpackage

`default_nettype wire

// File: hdl/rswm_cell.sv
// One cell of the pixel delay chain: holds one past pixel and passes it on.
// Drives its pixel onto the tap bus when its position matches the window.
// Depends on rswm_pkg.
`default_nettype none

module rswm_cell (
   input  wire                                clock,
   input  wire                                shift_en,
   input  wire  [rswm_pkg::WIN_IDX_W-1:0]     index,
   input  wire  [rswm_pkg::WIN_IDX_W-1:0]     tap_sel,
   input  wire  [rswm_pkg::PIXEL_W-1:0]       data_in,
   output logic [rswm_pkg::PIXEL_W-1:0]       data_out,
   output logic [rswm_pkg::PIXEL_W-1:0]       tap_out
);

   logic [rswm_pkg::PIXEL_W-1:0] data_ff;
   logic [rswm_pkg::PIXEL_W-1:0] data_in_mux;

   assign data_in_mux = shift_en ? data_in : data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in_mux;
   end

   assign data_out = data_ff;
   assign tap_out  = (index == tap_sel) ? data_ff : '0;

endmodule

`default_nettype wire

// File: hdl/rswm_div.sv
// Restoring divider for the window mean, one quotient bit per cycle.
// Holds its quotient until the top level takes it.
// Depends on rswm_pkg.
`default_nettype none

module rswm_div (
   input  wire                              clock,
   input  wire                              reset,
   input  rswm_pkg::div_req_type            div_req,
   input  wire                              take,
   output logic                             busy,
   output logic                             done,
   output logic [rswm_pkg::PIXEL_W-1:0]     quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [rswm_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [rswm_pkg::SUM_W-1:0]        dq_ff, dq_in;
   logic [rswm_pkg::WIN_IDX_W-1:0]    rem_ff, rem_in;
   logic [rswm_pkg::WIN_W-1:0]        divisor_ff, divisor_in;
   logic [rswm_pkg::WIN_W-1:0]        trial;
   logic [rswm_pkg::WIN_W-1:0]        diff;

   assign trial = {rem_ff, dq_ff[rswm_pkg::SUM_W-1]};
   assign diff  = trial - divisor_ff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = done_ff;
      step_in    = step_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (take) begin
         done_in = 1'b0;
      end
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         dq_in      = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= divisor_ff) begin
            rem_in = diff[rswm_pkg::WIN_IDX_W-1:0];
            dq_in  = {dq_ff[rswm_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[rswm_pkg::WIN_IDX_W-1:0];
            dq_in  = {dq_ff[rswm_pkg::SUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == rswm_pkg::STEP_W'(rswm_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dq_ff[rswm_pkg::PIXEL_W-1:0];

endmodule

`default_nettype wire

// File: hdl/row_sliding_window_mean_unit.sv
// Top level of the row sliding window mean unit.
// Instantiates the pixel delay chain (rswm_cell) and the divider (rswm_div).
// Depends on rswm_pkg.
//
// Pixels enter in raster order on the req_ channel, one per request. The
// column counter restarts after row_width pixels and the running sum is
// cleared at each row start. Once a full window of window_len pixels of the
// current row is in the sum, the rsp_ channel returns the truncated mean and
// the column where that window starts; earlier pixels of a row return
// nothing. The user must write the registers on the csr_ channel (index 0
// window_len, index 1 row_width) only while the unit is idle; the block
// does not enforce this. csr_ready is high outside reset. A request that
// gives no response does not hold up the next one. A request that gives a
// response occupies the 14-step serial divider, and the next request is
// taken once the divider has handed its quotient to the output register.
// A stalled receiver holds the output register and the finished quotient,
// and req_ready stays low until they move on.
// Reset clears the sum, the column, the divider and the output valid, holds
// both ready outputs low, and restores window_len 8 and row_width 640. The
// delay chain needs no reset.
`default_nettype none

module row_sliding_window_mean_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [rswm_pkg::PIXEL_W-1:0]        req_pixel,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [rswm_pkg::PIXEL_W-1:0]        rsp_mean,
   output logic [rswm_pkg::COL_W-1:0]          rsp_start_column,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [rswm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [rswm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [rswm_pkg::WIN_W-1:0]    win_ff, win_in;
   logic [rswm_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [rswm_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [rswm_pkg::COL_W-1:0]    col_ff, col_in;
   logic [rswm_pkg::COL_W-1:0]    pend_col_ff, pend_col_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rswm_pkg::PIXEL_W-1:0]  mean_ff, mean_in;
   logic [rswm_pkg::COL_W-1:0]    start_col_ff, start_col_in;

   logic [rswm_pkg::WIN_W-1:0]    win_eff;
   logic [rswm_pkg::ROW_W-1:0]    row_eff;
   logic [rswm_pkg::WIN_IDX_W-1:0] tap_sel;
   logic [rswm_pkg::ROW_W-1:0]    col_next;
   logic [rswm_pkg::ROW_W-1:0]    col_ext;
   logic                          accept;
   logic                          emit;
   logic [rswm_pkg::SUM_W-1:0]    sum_base;
   logic [rswm_pkg::PIXEL_W-1:0]  old_pixel;
   logic [rswm_pkg::ROW_W-1:0]    start_calc;

   logic [rswm_pkg::PIXEL_W-1:0]  chain [rswm_pkg::MAX_WINDOW];
   logic [rswm_pkg::PIXEL_W-1:0]  taps  [rswm_pkg::MAX_WINDOW];

   rswm_pkg::div_req_type         div_req;
   logic                          div_busy;
   logic                          div_done;
   logic                          div_take;
   logic [rswm_pkg::PIXEL_W-1:0]  div_quotient;

   always_comb begin
      if (win_ff == '0) begin
         win_eff = rswm_pkg::WIN_W'(1);
      end else if (win_ff > rswm_pkg::WIN_W'(rswm_pkg::MAX_WINDOW)) begin
         win_eff = rswm_pkg::WIN_W'(rswm_pkg::MAX_WINDOW);
      end else begin
         win_eff = win_ff;
      end
      if (row_ff == '0) begin
         row_eff = rswm_pkg::ROW_W'(1);
      end else if (row_ff > rswm_pkg::ROW_W'(rswm_pkg::MAX_ROW_WIDTH)) begin
         row_eff = rswm_pkg::ROW_W'(rswm_pkg::MAX_ROW_WIDTH);
      end else begin
         row_eff = row_ff;
      end
   end

   assign tap_sel = rswm_pkg::WIN_IDX_W'(win_eff - 1'b1);

   genvar k;
   generate
      for (k = 0; k < rswm_pkg::MAX_WINDOW; k++) begin : g_cell
         rswm_cell u_cell (
            .clock    (clock),
            .shift_en (accept),
            .index    (rswm_pkg::WIN_IDX_W'(k)),
            .tap_sel  (tap_sel),
            .data_in  ((k == 0) ? req_pixel : chain[(k == 0) ? 0 : k - 1]),
            .data_out (chain[k]),
            .tap_out  (taps[k])
         );
      end
   endgenerate

   always_comb begin
      old_pixel = '0;
      for (int i = 0; i < rswm_pkg::MAX_WINDOW; i++) begin
         old_pixel = old_pixel | taps[i];
      end
   end

   assign req_ready = !reset && !div_busy && !div_done;
   assign accept    = req_valid && req_ready;
   assign csr_ready = !reset;

   assign col_ext    = {1'b0, col_ff};
   assign col_next   = col_ext + 1'b1;
   assign emit       = col_next >= rswm_pkg::ROW_W'(win_eff);
   assign start_calc = col_next - rswm_pkg::ROW_W'(win_eff);

   always_comb begin
      sum_base = (col_ff == '0) ? '0 : sum_ff;
      if (col_ext >= rswm_pkg::ROW_W'(win_eff)) begin
         sum_base = sum_base - rswm_pkg::SUM_W'(old_pixel);
      end
   end

   always_comb begin
      win_in      = win_ff;
      row_in      = row_ff;
      sum_in      = sum_ff;
      col_in      = col_ff;
      pend_col_in = pend_col_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rswm_pkg::CSR_WINDOW_LEN: win_in = csr_wdata[rswm_pkg::WIN_W-1:0];
            rswm_pkg::CSR_ROW_WIDTH:  row_in = csr_wdata[rswm_pkg::ROW_W-1:0];
            default: begin
            end
         endcase
      end
      if (accept) begin
         sum_in = sum_base + rswm_pkg::SUM_W'(req_pixel);
         if (col_next >= row_eff) begin
            col_in = '0;
         end else begin
            col_in = col_next[rswm_pkg::COL_W-1:0];
         end
         if (emit) begin
            pend_col_in = start_calc[rswm_pkg::COL_W-1:0];
         end
      end
   end

   always_comb begin
      div_req.start    = accept && emit;
      div_req.dividend = sum_in;
      div_req.divisor  = win_eff;
   end

   rswm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .take     (div_take),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign div_take = div_done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      mean_in      = mean_ff;
      start_col_in = start_col_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (div_take) begin
         rsp_valid_in = 1'b1;
         mean_in      = div_quotient;
         start_col_in = pend_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= rswm_pkg::WIN_RESET;
         row_ff       <= rswm_pkg::ROW_RESET;
         sum_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         row_ff       <= row_in;
         sum_ff       <= sum_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_col_ff  <= pend_col_in;
      mean_ff      <= mean_in;
      start_col_ff <= start_col_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean         = mean_ff;
   assign rsp_start_column = start_col_ff;

endmodule

`default_nettype wire
